// ===== src/midtone_stretch_pixel_mapper_top_defines.svh =====
// ----------------------------------------------------------------------------
// Midtone stretch pixel mapper assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIDTONE_STRETCH_PIXEL_MAPPER_TOP_DEFINES_SVH
`define MIDTONE_STRETCH_PIXEL_MAPPER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MSP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define MSP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared widths, register indexes and pipeline control type of the mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int COEFF_W         = 48;
	localparam int OUT_W           = 8;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	// eight quotient bits plus one overflow bit
	localparam int QUO_BITS        = OUT_W + 1;
	localparam int APB_DATA_W      = 64;
	localparam int APB_ADDR_W      = 5;

	localparam logic [OUT_W-1:0]    OUT_MAX    = 8'hFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		REG_BLACK = 2'd0,
		REG_WHITE = 2'd1,
		REG_GAIN  = 2'd2,
		REG_POLE  = 2'd3
	} reg_idx_t;

	// result already decided before the divider
	typedef struct packed {
		logic             pinned;
		logic [OUT_W-1:0] pin_val;
	} msp_ctl_t;

	function automatic int max_i(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int num_w(input int sb);
		return COEFF_W + sb + 1;
	endfunction

	function automatic int den_w(input int sb, input int fb);
		return max_i(sb + fb + 1, COEFF_W) + 1;
	endfunction

	function automatic int cmp_w(input int sb, input int fb);
		return max_i(num_w(sb), den_w(sb, fb) + OUT_W);
	endfunction

endpackage

`default_nettype wire

// ===== src/msp_front.sv =====
// ----------------------------------------------------------------------------
// msp_front
// Three pipeline stages: clamp and offset, product and denominator, magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midtone_stretch_pixel_mapper_top_defines.svh"

module msp_front
	import msp_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int NUM_W      = num_w(SAMPLE_BITS),
	localparam int DEN_W      = den_w(SAMPLE_BITS, FRAC_BITS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [SAMPLE_W-1:0]       in_sample,
	input  logic [SAMPLE_W-1:0]       black,
	input  logic [SAMPLE_W-1:0]       white,
	input  logic signed [COEFF_W-1:0] gain,
	input  logic signed [COEFF_W-1:0] pole,
	input  logic [2:0]                en,
	output logic [2:0]                v_o,
	output logic [NUM_W-1:0]          nmag,
	output logic [DEN_W-1:0]          dmag,
	output msp_ctl_t                  ctl
);

	logic [SAMPLE_BITS-1:0] s_m, b_m, w_m;
	logic                   below, above;

	logic                   v_s1, v_s2, v_s3;
	logic [SAMPLE_BITS-1:0] x_s1;
	msp_ctl_t               ctl_s1, ctl_s2, ctl_s3;
	logic signed [NUM_W-1:0] num_s2;
	logic signed [DEN_W-1:0] den_s2;
	logic [NUM_W-1:0]       nmag_s3;
	logic [DEN_W-1:0]       dmag_s3;

	logic signed [DEN_W-1:0] xsh, pole_x, den_c;
	logic                    nneg, dneg;
	logic [NUM_W-1:0]        nmag_c;
	logic [DEN_W-1:0]        dmag_c;
	msp_ctl_t                ctl_c;

	assign s_m   = in_sample[SAMPLE_BITS-1:0];
	assign b_m   = black[SAMPLE_BITS-1:0];
	assign w_m   = white[SAMPLE_BITS-1:0];
	assign below = s_m < b_m;
	assign above = s_m > w_m;

	assign xsh    = DEN_W'({x_s1, {FRAC_BITS{1'b0}}});
	assign pole_x = DEN_W'(pole);
	assign den_c  = xsh - pole_x;

	assign nneg   = num_s2[NUM_W-1];
	assign dneg   = den_s2[DEN_W-1];
	assign nmag_c = nneg ? NUM_W'(-num_s2) : NUM_W'(num_s2);
	assign dmag_c = dneg ? DEN_W'(-den_s2) : DEN_W'(den_s2);

	always_comb begin
		ctl_c = ctl_s2;
		if (!ctl_s2.pinned) begin
			if (den_s2 == '0) begin
				ctl_c.pinned  = 1'b1;
				ctl_c.pin_val = OUT_MAX;
			end else if (nneg ^ dneg) begin
				// quotient is zero or negative
				ctl_c.pinned  = 1'b1;
				ctl_c.pin_val = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en[0]) v_s1 <= in_valid;
			if (en[1]) v_s2 <= v_s1;
			if (en[2]) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1           <= s_m - b_m;
			ctl_s1.pinned  <= below || above;
			ctl_s1.pin_val <= below ? '0 : OUT_MAX;
		end
		if (en[1]) begin
			num_s2 <= $signed(gain) * $signed({1'b0, x_s1});
			den_s2 <= den_c;
			ctl_s2 <= ctl_s1;
		end
		if (en[2]) begin
			nmag_s3 <= nmag_c;
			dmag_s3 <= dmag_c;
			ctl_s3  <= ctl_c;
		end
	end

	assign v_o  = {v_s3, v_s2, v_s1};
	assign nmag = nmag_s3;
	assign dmag = dmag_s3;
	assign ctl  = ctl_s3;

	`MSP_ASSERT_IMP(a_den_nonzero, v_s3 && !ctl_s3.pinned, dmag_s3 != '0,
		"unpinned item reached divider with zero denominator")

endmodule

`default_nettype wire

// ===== src/msp_div_stage.sv =====
// ----------------------------------------------------------------------------
// msp_div_stage
// One registered restoring division step for quotient bit SHIFT.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_div_stage
	import msp_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SHIFT       = 0,
	localparam int NUM_W      = num_w(SAMPLE_BITS),
	localparam int DEN_W      = den_w(SAMPLE_BITS, FRAC_BITS),
	localparam int CMP_W      = cmp_w(SAMPLE_BITS, FRAC_BITS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [NUM_W-1:0]    rem_i,
	input  logic [DEN_W-1:0]    dmag_i,
	input  logic [QUO_BITS-1:0] q_i,
	input  msp_ctl_t            ctl_i,
	output logic                valid_o,
	output logic [NUM_W-1:0]    rem_o,
	output logic [DEN_W-1:0]    dmag_o,
	output logic [QUO_BITS-1:0] q_o,
	output msp_ctl_t            ctl_o
);

	logic [CMP_W:0]        dsh, diff;
	logic                  ge;
	logic [QUO_BITS-1:0]   q_c;

	logic                  v_s1;
	logic [NUM_W-1:0]      rem_s1;
	logic [DEN_W-1:0]      dmag_s1;
	logic [QUO_BITS-1:0]   q_s1;
	msp_ctl_t              ctl_s1;

	assign dsh  = (CMP_W + 1)'(dmag_i) << SHIFT;
	assign diff = (CMP_W + 1)'(rem_i) - dsh;
	assign ge   = !diff[CMP_W];

	always_comb begin
		q_c        = q_i;
		q_c[SHIFT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? diff[NUM_W-1:0] : rem_i;
			dmag_s1 <= dmag_i;
			q_s1    <= q_c;
			ctl_s1  <= ctl_i;
		end
	end

	assign valid_o = v_s1;
	assign rem_o   = rem_s1;
	assign dmag_o  = dmag_s1;
	assign q_o     = q_s1;
	assign ctl_o   = ctl_s1;

endmodule

`default_nettype wire

// ===== src/midtone_stretch_pixel_mapper_top.sv =====
// Pipeline: 13 register stages from the input transfer to the result on m_tvalid/m_tdata.
// Throughput: one sample per cycle; a new sample enters every cycle the pipe moves.
// Depth is set by 3 front stages, 9 one-bit divider stages and the output register.
// Each stage stalls only when it holds an item and the stage after it is blocked.
// Reset clears all stage valid bits and loads the registers with their defaults.
// ----------------------------------------------------------------------------
// midtone_stretch_pixel_mapper_top
// Maps a raw sample through a clamped rational midtone curve to 8 bits,
// with an APB register port for the black/white points and curve coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midtone_stretch_pixel_mapper_top_defines.svh"

module midtone_stretch_pixel_mapper_top
	import msp_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// sample stream in
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
	// display stream out
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata    // [7:0] display_out
);

	localparam int NUM_W = num_w(SAMPLE_BITS);
	localparam int DEN_W = den_w(SAMPLE_BITS, FRAC_BITS);
	localparam int NSTG  = 3 + QUO_BITS + 1;

	logic [SAMPLE_W-1:0]       black_q, white_q;
	logic signed [COEFF_W-1:0] gain_q, pole_q;
	logic                      wr_en;
	reg_idx_t                  reg_sel;

	logic [NSTG-1:0]     v, en;
	logic [NUM_W-1:0]    rem_a  [0:QUO_BITS];
	logic [DEN_W-1:0]    dmag_a [0:QUO_BITS];
	logic [QUO_BITS-1:0] q_a    [0:QUO_BITS];
	msp_ctl_t            ctl_a  [0:QUO_BITS];

	logic                v_s13;
	logic [OUT_W-1:0]    disp_s13;
	logic [OUT_W-1:0]    disp_c;
	msp_ctl_t            ctl_l;
	logic [QUO_BITS-1:0] q_l;

	// ---------------- registers ----------------
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q <= '0;
			white_q <= SAMPLE_MAX;
			gain_q  <= '0;
			pole_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_BLACK: black_q <= pwdata[SAMPLE_W-1:0];
				REG_WHITE: white_q <= pwdata[SAMPLE_W-1:0];
				REG_GAIN:  gain_q  <= pwdata[COEFF_W-1:0];
				REG_POLE:  pole_q  <= pwdata[COEFF_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_BLACK: prdata = APB_DATA_W'(black_q);
			REG_WHITE: prdata = APB_DATA_W'(white_q);
			REG_GAIN:  prdata = APB_DATA_W'(gain_q);
			REG_POLE:  prdata = APB_DATA_W'(pole_q);
		endcase
	end

	// ---------------- stall chain ----------------
	// a stage may load when it is empty or its successor loads
	assign en[NSTG-1] = !v[NSTG-1] || m_tready;
	for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
		assign en[k] = !v[k] || en[k+1];
	end

	assign s_tready = en[0];

	// ---------------- front stages ----------------
	msp_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_sample (s_tdata),
		.black     (black_q),
		.white     (white_q),
		.gain      (gain_q),
		.pole      (pole_q),
		.en        (en[2:0]),
		.v_o       (v[2:0]),
		.nmag      (rem_a[0]),
		.dmag      (dmag_a[0]),
		.ctl       (ctl_a[0])
	);

	assign q_a[0] = '0;

	// ---------------- divider stages, overflow bit first ----------------
	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		msp_div_stage #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.FRAC_BITS   (FRAC_BITS),
			.SHIFT       (QUO_BITS - 1 - k)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en[3+k]),
			.in_valid (v[2+k]),
			.rem_i    (rem_a[k]),
			.dmag_i   (dmag_a[k]),
			.q_i      (q_a[k]),
			.ctl_i    (ctl_a[k]),
			.valid_o  (v[3+k]),
			.rem_o    (rem_a[k+1]),
			.dmag_o   (dmag_a[k+1]),
			.q_o      (q_a[k+1]),
			.ctl_o    (ctl_a[k+1])
		);
	end

	// ---------------- output register ----------------
	assign ctl_l = ctl_a[QUO_BITS];
	assign q_l   = q_a[QUO_BITS];

	always_comb begin
		if (ctl_l.pinned) begin
			disp_c = ctl_l.pin_val;
		end else if (q_l[QUO_BITS-1]) begin
			disp_c = OUT_MAX;
		end else begin
			disp_c = q_l[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (en[NSTG-1]) begin
			v_s13 <= v[NSTG-2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			disp_s13 <= disp_c;
		end
	end

	assign v[NSTG-1] = v_s13;
	assign m_tvalid  = v_s13;
	assign m_tdata   = disp_s13;

	`MSP_ASSERT_IMP(a_rdy_when_empty, !m_tvalid, s_tready,
		"input stalled while output register is empty")
	`MSP_ASSERT_IMP(a_rdy_when_sink, m_tready, s_tready,
		"input stalled while output is being drained")

endmodule

`default_nettype wire
